// ===== rtl/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
// No dependencies; used by double_ended_queue.

package deq_pkg;

    localparam int unsigned CAPACITY_DEF = 16;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned ACTION_W     = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } t_action;

endpackage

// ===== rtl/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit values in a ring buffer.
// Depends on deq_pkg for action codes, widths and the default capacity.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one transaction: an action
//   (push front, push back, pop front, pop back) and a push value.
//   Output channel (o_valid / i_ready) returns exactly one result per
//   transaction: success flag, popped value (zero unless a pop succeeded)
//   and the empty flag after the step.
//   A result appears the cycle after its transaction is accepted.
//   Throughput is one transaction per cycle while the receiver takes each
//   result; the front pointer and element count update at acceptance, and
//   the element store is a single-port synchronous memory with a registered read.
//   A push writes the memory at acceptance; a pop accepted after it reads
//   the memory at its own acceptance, so no forwarding path is needed.
//   Reset empties the queue (front pointer and count to zero) and drops
//   any pending result. Stored data is not cleared.
//   When the receiver stalls, the result register holds and o_ready drops
//   until the result is taken; it rises again in the cycle i_ready is high.

module double_ended_queue #(
    parameter int unsigned CAPACITY = deq_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [deq_pkg::ACTION_W-1:0]      i_action,
    input  logic signed [deq_pkg::DATA_W-1:0] i_push_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_success,
    output logic signed [deq_pkg::DATA_W-1:0] o_popped_value,
    output logic                              o_now_empty
);

    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned SW = CW + 1;

    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
    localparam logic [SW-1:0] CAP_SUM  = SW'(CAPACITY);

    logic [deq_pkg::DATA_W-1:0] mem [CAPACITY];

    logic [IW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic          r_valid;
    logic          r_success;
    logic          r_is_pop;
    logic          r_empty;
    logic [deq_pkg::DATA_W-1:0] r_rd_data;

    logic          accept;
    logic          full;
    logic          empty;
    logic          ok;
    logic          is_pop;
    logic          mem_we;
    logic          mem_re;
    logic [IW-1:0] addr;
    logic [IW-1:0] front_prev;
    logic [IW-1:0] front_next;
    logic [IW-1:0] back_idx;
    logic [IW-1:0] tail_idx;
    logic [SW-1:0] back_sum;
    logic [SW-1:0] tail_sum;
    logic [CW-1:0] count_m1;
    deq_pkg::t_action action;

    assign action  = deq_pkg::t_action'(i_action);
    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign full    = (r_count == CAP_CNT);
    assign empty   = (r_count == '0);
    assign count_m1 = r_count - CW'(1);

    // ring positions
    assign front_prev = (r_front == '0) ? LAST_IDX : r_front - IW'(1);
    assign front_next = (r_front == LAST_IDX) ? '0 : r_front + IW'(1);
    assign back_sum   = SW'(r_front) + SW'(r_count);
    assign tail_sum   = SW'(r_front) + SW'(count_m1);
    assign back_idx   = (back_sum >= CAP_SUM) ? IW'(back_sum - CAP_SUM) : IW'(back_sum);
    assign tail_idx   = (tail_sum >= CAP_SUM) ? IW'(tail_sum - CAP_SUM) : IW'(tail_sum);

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        ok      = 1'b0;
        is_pop  = 1'b0;
        addr    = r_front;
        case (action)
            deq_pkg::ACT_PUSH_FRONT: begin
                ok   = !full;
                addr = front_prev;
                if (ok) begin
                    n_front = front_prev;
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::ACT_PUSH_BACK: begin
                ok   = !full;
                addr = back_idx;
                if (ok) begin
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::ACT_POP_FRONT: begin
                ok     = !empty;
                is_pop = 1'b1;
                addr   = r_front;
                if (ok) begin
                    n_front = front_next;
                    n_count = count_m1;
                end
            end
            default: begin
                ok     = !empty;
                is_pop = 1'b1;
                addr   = tail_idx;
                if (ok) begin
                    n_count = count_m1;
                end
            end
        endcase
    end

    assign mem_we = accept && ok && !is_pop;
    assign mem_re = accept && ok && is_pop;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[addr] <= i_push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_front <= n_front;
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_success <= ok;
            r_is_pop  <= is_pop;
            r_empty   <= (n_count == '0);
        end
    end

    assign o_valid        = r_valid;
    assign o_success      = r_success;
    assign o_now_empty    = r_empty;
    assign o_popped_value = (r_success && r_is_pop) ? r_rd_data : '0;

endmodule
